// ----- design/fct_pkg.sv -----
// Package with the shared types, codes and constants of the frustum culling test.
`timescale 1ns / 1ps
package fct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int REG_COUNT   = 6;
    localparam int ADDR_W      = 6;
    localparam int COORD_W     = 24;
    localparam int RADIUS_W    = 23;
    localparam int NORM_W      = 12;
    localparam int OFFS_W      = 28;
    localparam int PROD_W      = NORM_W + COORD_W;
    localparam int BIAS_W      = OFFS_W + 11;
    localparam int DIST_W      = 42;

    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_BOX    = 2'd2;

    localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd1;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

    typedef logic [63:0] plane_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic [RADIUS_W-1:0]       radius;
        logic [1:0]                verdict;
        logic                      done;
    } item_t;

endpackage

// ----- design/frustum_cull_test.sv -----
// Top level of the frustum culling test: plane registers and a chain of plane cells.
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_stall        operation, first_*, second_*, sphere_radius
//  result    out        result_valid / result_stall    verdict
//  config    in         APB psel/penable/pwrite        paddr, pwdata, prdata
//
// One item is accepted per cycle while item_stall is low; each result passes through every plane cell.
// Each plane cell has a product stage and a distance stage; items advance one stage a cycle unless stalled.
// Reset clears all planes to zero and empties the chain.
// A stalled result holds the whole chain, so item_stall follows it in the same cycle.
`timescale 1ns / 1ps
module frustum_cull_test
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fct_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [1:0]                   operation,
    input  logic signed [23:0]           first_x,
    input  logic signed [23:0]           first_y,
    input  logic signed [23:0]           first_z,
    input  logic signed [23:0]           second_x,
    input  logic signed [23:0]           second_y,
    input  logic signed [23:0]           second_z,
    input  logic [22:0]                  sphere_radius,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [1:0]                   verdict
);
    import fct_pkg::*;

    plane_t planes [REG_COUNT];
    item_t  items  [PLANE_COUNT+1];
    logic   vlds   [PLANE_COUNT+1];
    logic   en;

    assign pready = 1'b1;

    fct_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .planes  (planes)
    );

    assign en         = !(vlds[PLANE_COUNT] && result_stall);
    assign item_stall = !en;

    always_comb
    begin
        vlds[0]            = item_valid;
        items[0].operation = operation;
        items[0].a_x       = first_x;
        items[0].a_y       = first_y;
        items[0].a_z       = first_z;
        items[0].b_x       = second_x;
        items[0].b_y       = second_y;
        items[0].b_z       = second_z;
        items[0].radius    = sphere_radius;
        items[0].verdict   = VERDICT_INSIDE;
        items[0].done      = 1'b0;
    end

    for (genvar k = 0; k < PLANE_COUNT; k++)
    begin : g_cell
        fct_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .plane    (planes[k]),
            .in_vld   (vlds[k]),
            .in_item  (items[k]),
            .out_vld  (vlds[k+1]),
            .out_item (items[k+1])
        );
    end

    assign result_valid = vlds[PLANE_COUNT];
    assign verdict      = items[PLANE_COUNT].verdict;

endmodule

// ----- design/fct_cell.sv -----
// One plane cell: products in the first stage, corner distances and verdict update in the second.
`timescale 1ns / 1ps
module fct_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  fct_pkg::plane_t plane,
    input  logic           in_vld,
    input  fct_pkg::item_t in_item,
    output logic           out_vld,
    output fct_pkg::item_t out_item
);
    import fct_pkg::*;

    logic signed [NORM_W-1:0] nx, ny, nz;
    logic signed [OFFS_W-1:0] d;
    logic [RADIUS_W-1:0]      r_eff;

    logic                     s1_vld_reg;
    item_t                    s1_item_reg;
    logic signed [PROD_W-1:0] pxa_reg, pxb_reg, pya_reg, pyb_reg, pza_reg, pzb_reg;
    logic signed [BIAS_W-1:0] bias_reg;
    logic signed [PROD_W-1:0] pxa_next, pxb_next, pya_next, pyb_next, pza_next, pzb_next;
    logic signed [BIAS_W-1:0] bias_next;

    logic                     s2_vld_reg;
    item_t                    s2_item_reg;
    item_t                    s2_item_next;
    logic signed [DIST_W-1:0] corner_dist [8];
    logic [7:0]               neg;

    assign nx = plane[11:0];
    assign ny = plane[23:12];
    assign nz = plane[35:24];
    assign d  = plane[63:36];

    always_comb
    begin
        r_eff     = (in_item.operation == OP_SPHERE) ? in_item.radius : '0;
        pxa_next  = nx * in_item.a_x;
        pxb_next  = nx * in_item.b_x;
        pya_next  = ny * in_item.a_y;
        pyb_next  = ny * in_item.b_y;
        pza_next  = nz * in_item.a_z;
        pzb_next  = nz * in_item.b_z;
        bias_next = {d[OFFS_W-1], d, 10'b0} + {6'b0, r_eff, 10'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= in_item;
            pxa_reg     <= pxa_next;
            pxb_reg     <= pxb_next;
            pya_reg     <= pya_next;
            pyb_reg     <= pyb_next;
            pza_reg     <= pza_next;
            pzb_reg     <= pzb_next;
            bias_reg    <= bias_next;
            s2_item_reg <= s2_item_next;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            corner_dist[j] = DIST_W'(j[0] ? pxb_reg : pxa_reg)
                           + DIST_W'(j[1] ? pyb_reg : pya_reg)
                           + DIST_W'(j[2] ? pzb_reg : pza_reg)
                           + DIST_W'(bias_reg);
            neg[j]         = corner_dist[j][DIST_W-1];
        end
        s2_item_next = s1_item_reg;
        if (!s1_item_reg.done)
        begin
            case (s1_item_reg.operation)
                OP_POINT, OP_SPHERE:
                begin
                    if (neg[0] || (corner_dist[0] == '0))
                    begin
                        s2_item_next.verdict = VERDICT_OUTSIDE;
                        s2_item_next.done    = 1'b1;
                    end
                end
                OP_BOX:
                begin
                    if (&neg)
                    begin
                        s2_item_next.verdict = VERDICT_OUTSIDE;
                        s2_item_next.done    = 1'b1;
                    end
                    else if (|neg)
                    begin
                        s2_item_next.verdict = VERDICT_INTERSECT;
                    end
                end
                default:
                begin
                    s2_item_next.done = 1'b1;
                end
            endcase
        end
    end

    assign out_vld  = s2_vld_reg;
    assign out_item = s2_item_reg;

endmodule

// ----- design/fct_regs.sv -----
// APB register file holding the frustum planes.
`timescale 1ns / 1ps
module fct_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fct_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output fct_pkg::plane_t           planes [fct_pkg::REG_COUNT]
);
    import fct_pkg::*;

    logic [2:0] idx;

    assign idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                planes[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && (idx < 3'(REG_COUNT)))
        begin
            planes[idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (idx == 3'(i))
            begin
                prdata = planes[i];
            end
        end
    end

endmodule

// ----- design/fct_checker.sv -----
// Port checker for the frustum culling test, bound to the top level.
`timescale 1ns / 1ps
module fct_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [1:0] verdict
);
    import fct_pkg::*;

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("Stalled result was withdrawn.");

    a_verdict_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(verdict))
        else $error("Stalled verdict changed.");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (verdict == VERDICT_INSIDE || verdict == VERDICT_OUTSIDE
                          || verdict == VERDICT_INTERSECT))
        else $error("Verdict carries an unused code.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("Input stalled without a stalled result.");

endmodule

bind frustum_cull_test fct_checker u_fct_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .verdict      (verdict)
);

// ----- tb/sv/frustum_cull_test_tb.sv -----
// Self-checking testbench of the frustum culling test: planes over the register port, checked verdicts.
`timescale 1ns / 1ps
module frustum_cull_test_tb;
    import fct_pkg::*;

    typedef struct {
        logic [1:0]         op;
        logic signed [23:0] ax, ay, az, bx, by, bz;
        logic [22:0]        rad;
    } cull_item_t;

    class cull_scoreboard;
        plane_t      plane_regs[PLANE_COUNT];
        logic [1:0]  pending_verdicts[$];
        int          mismatches;
        int          verdicts_seen;

        function longint plane_distance(int k, longint x, longint y, longint z,
                                        longint r);
            logic signed [11:0] nx, ny, nz;
            logic signed [27:0] d;
            nx = plane_regs[k][11:0];
            ny = plane_regs[k][23:12];
            nz = plane_regs[k][35:24];
            d  = plane_regs[k][63:36];
            return longint'(nx) * x + longint'(ny) * y + longint'(nz) * z
                   + longint'(d) * 1024 + r * 1024;
        endfunction

        function void note_item(cull_item_t it);
            logic [1:0] v;
            int nin, nout;
            longint cx, cy, cz;
            v = VERDICT_INSIDE;
            if (it.op == OP_POINT || it.op == OP_SPHERE) begin
                for (int k = 0; k < PLANE_COUNT; k++)
                    if (plane_distance(k, it.ax, it.ay, it.az,
                                       it.op == OP_SPHERE ? longint'(it.rad) : 0) <= 0) begin
                        v = VERDICT_OUTSIDE;
                        break;
                    end
            end else if (it.op == OP_BOX) begin
                for (int k = 0; k < PLANE_COUNT; k++) begin
                    nin = 0;
                    nout = 0;
                    for (int j = 0; j < 8; j++) begin
                        cx = j[0] ? it.bx : it.ax;
                        cy = j[1] ? it.by : it.ay;
                        cz = j[2] ? it.bz : it.az;
                        if (plane_distance(k, cx, cy, cz, 0) < 0) nout++;
                        else nin++;
                    end
                    if (nin == 0) begin
                        v = VERDICT_OUTSIDE;
                        break;
                    end
                    if (nout != 0) v = VERDICT_INTERSECT;
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_verdict(logic [1:0] got);
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("unexpected verdict %0d", got));
            else if (pending_verdicts[0] !== got) begin
                report_mismatch($sformatf("verdict %0d, expected %0d", got, pending_verdicts[0]));
                void'(pending_verdicts.pop_front());
            end else
                void'(pending_verdicts.pop_front());
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic item_valid = 0;
    logic item_stall;
    logic [1:0] operation = '0;
    logic signed [23:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [23:0] second_x = '0, second_y = '0, second_z = '0;
    logic [22:0] sphere_radius = '0;
    logic result_valid;
    logic result_stall = 0;
    logic [1:0] verdict;

    cull_scoreboard sb;
    int cycle_count = 0;
    int items_sent = 0;
    int stall_mode = 0;

    always #4 clk = ~clk;

    frustum_cull_test uut (.*);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout with %0d verdicts outstanding", sb.pending_verdicts.size());
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && result_valid && !result_stall) sb.check_verdict(verdict);
    end

    always @(negedge clk) begin
        case (stall_mode)
            0: result_stall <= 0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= cycle_count[3];
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    end

    task automatic write_plane(int idx, plane_t value);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= ADDR_W'(8 * idx); pwdata <= value;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        sb.plane_regs[idx] = value;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    function automatic plane_t make_plane(logic [11:0] nx, logic [11:0] ny, logic [11:0] nz,
                                          logic [27:0] d);
        return {d, nz, ny, nx};
    endfunction

    task automatic send_item(cull_item_t it);
        @(negedge clk);
        item_valid <= 1;
        operation <= it.op;
        first_x <= it.ax; first_y <= it.ay; first_z <= it.az;
        second_x <= it.bx; second_y <= it.by; second_z <= it.bz;
        sphere_radius <= it.rad;
        do @(posedge clk); while (item_stall);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic pause_sender();
        @(negedge clk);
        item_valid <= 0;
    endtask

    task automatic wait_drained();
        while (sb.pending_verdicts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [23:0] rand_coord(bit narrow);
        if (narrow) return 24'(int'($urandom_range(0, 8000)) - 4000);
        return 24'($urandom);
    endfunction

    function automatic cull_item_t rand_item(bit narrow);
        cull_item_t it;
        it.op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        it.ax = rand_coord(narrow); it.ay = rand_coord(narrow); it.az = rand_coord(narrow);
        it.bx = rand_coord(narrow); it.by = rand_coord(narrow); it.bz = rand_coord(narrow);
        if (narrow && $urandom_range(0, 3) != 0) begin
            it.bx = it.ax + 24'($urandom_range(0, 3000));
            it.by = it.ay + 24'($urandom_range(0, 3000));
            it.bz = it.az + 24'($urandom_range(0, 3000));
        end
        it.rad = narrow ? 23'($urandom_range(0, 2000)) : 23'($urandom);
        return it;
    endfunction

    // A box-shaped frustum of half-width 2000 coordinate units around the origin, with normals in Q2.10.
    task automatic load_cube_planes();
        write_plane(0, make_plane(-12'sd1024, 0, 0, 28'sd2000));
        write_plane(1, make_plane(12'sd1024, 0, 0, 28'sd2000));
        write_plane(2, make_plane(0, 12'sd1024, 0, 28'sd2000));
        write_plane(3, make_plane(0, -12'sd1024, 0, 28'sd2000));
        write_plane(4, make_plane(0, 0, -12'sd1024, 28'sd2000));
        write_plane(5, make_plane(0, 0, 12'sd1024, 28'sd2000));
    endtask

    task automatic run_random(int count, bit narrow);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && count > 0) begin
                send_item(rand_item(narrow));
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) begin
                pause_sender();
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        pause_sender();
    endtask

    localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CMIN = -24'sh800000;

    initial begin
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Reset planes are all zero, so every point and box distance is zero and a sphere's is its radius times 1024.
        send_item('{OP_POINT, 0, 0, 0, 0, 0, 0, 0});
        send_item('{OP_SPHERE, 5, 5, 5, 0, 0, 0, 23'h7FFFFF});
        send_item('{OP_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0});
        pause_sender();
        wait_drained();

        load_cube_planes();
        send_item('{OP_POINT, 0, 0, 0, 0, 0, 0, 0});
        send_item('{OP_POINT, 24'sd2000, 0, 0, 0, 0, 0, 0});
        send_item('{OP_POINT, 24'sd1999, -24'sd1999, 0, 0, 0, 0, 0});
        send_item('{OP_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0});
        send_item('{OP_POINT, CMIN, CMIN, CMIN, 0, 0, 0, 0});
        send_item('{OP_SPHERE, 24'sd3000, 0, 0, 0, 0, 0, 23'd1001});
        send_item('{OP_SPHERE, 24'sd3000, 0, 0, 0, 0, 0, 23'd1000});
        send_item('{OP_SPHERE, CMIN, 0, 0, 0, 0, 0, 23'h7FFFFF});
        send_item('{OP_BOX, -24'sd100, -24'sd100, -24'sd100, 24'sd100, 24'sd100, 24'sd100, 0});
        send_item('{OP_BOX, -24'sd100, -24'sd100, -24'sd100, 24'sd3000, 24'sd100, 24'sd100, 0});
        send_item('{OP_BOX, 24'sd2500, 0, 0, 24'sd3000, 24'sd100, 24'sd100, 0});
        send_item('{OP_BOX, 24'sd100, 24'sd100, 24'sd100, -24'sd100, -24'sd100, -24'sd100, 0});
        send_item('{OP_BOX, 24'sd2000, 0, 0, 24'sd2000, 0, 0, 0});
        send_item('{OP_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0});
        send_item('{2'd3, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 23'h7FFFFF});
        pause_sender();
        wait_drained();

        stall_mode = 1;
        run_random(300, 1);
        wait_drained();

        // Extreme plane values in planes 0 to 3, random values in the rest.
        write_plane(0, make_plane(12'h7FF, 12'h7FF, 12'h7FF, 28'h7FFFFFF));
        write_plane(1, make_plane(12'h800, 12'h800, 12'h800, 28'h8000000));
        write_plane(2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_plane(3, 64'h0);
        for (int i = 4; i < PLANE_COUNT; i++) write_plane(i, {$urandom, $urandom});
        stall_mode = 2;
        run_random(100, 0);
        wait_drained();

        for (int i = 0; i < PLANE_COUNT; i++)
            write_plane(i, make_plane(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                      12'($urandom_range(0, 4095)),
                                      28'(int'($urandom_range(0, 4000)) - 2000)));
        stall_mode = 3;
        run_random(150, 1);
        wait_drained();

        load_cube_planes();
        stall_mode = 0;
        run_random(100, 1);
        wait_drained();

        $display("Ran %0d items through zero, cube, extreme and random plane sets.", items_sent);
        $display("Checked %0d verdicts with %0d mismatches.", sb.verdicts_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
